>>> rtl/mmb_pkg.sv
package mmb_pkg;

    // Command codes of an input beat
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_CELL = 1'b1;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_COLUMN_COUNT = 3'd0,
        REG_ROW_COUNT    = 3'd1,
        REG_MAP_BANK     = 3'd2,
        REG_START_COLUMN = 3'd3,
        REG_START_ROW    = 3'd4
    } t_cfg_reg;

    // Field widths
    localparam int CELL_INDEX_W = 12;
    localparam int WORD_W       = 32;
    localparam int COUNT_W      = 8;
    localparam int BANK_W       = 2;
    localparam int START_W      = 4;

    // Destination map layout: 32 words per row, 4 bytes per word
    localparam int OFFSET_W   = 14;
    localparam int MAP_COL_W  = 5;
    localparam int BYTE_SEL_W = 2;
    localparam int MAP_ROW_W  = OFFSET_W - MAP_COL_W - BYTE_SEL_W;
    localparam logic [OFFSET_W-1:0] PAIR_GAP = 14'h0040;

    // Cell decoded by the cursor, handed to the output sequencer
    typedef struct packed {
        logic                emit;
        logic [OFFSET_W-1:0] offset;
        logic                done;
    } t_cell_issue;

endpackage

>>> rtl/mmb_table.sv
module mmb_table #(
    parameter int TABLE_ENTRIES = 4096
) (
    input  logic                               i_clk,
    input  logic                               i_wr_en,
    input  logic [$clog2(TABLE_ENTRIES)-1:0]   i_wr_addr,
    input  logic [2*mmb_pkg::WORD_W-1:0]       i_wr_data,
    input  logic                               i_rd_en,
    input  logic [$clog2(TABLE_ENTRIES)-1:0]   i_rd_addr,
    output logic [2*mmb_pkg::WORD_W-1:0]       o_rd_data
);
    import mmb_pkg::*;

    logic [2*WORD_W-1:0] r_mem [TABLE_ENTRIES];
    logic [2*WORD_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Hold read data until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/mmb_cursor.sv
module mmb_cursor #(
    parameter int WINDOW_SIZE = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr,
    input  logic [mmb_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [mmb_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_cell_accept,
    output mmb_pkg::t_cell_issue              o_issue
);
    import mmb_pkg::*;

    localparam int CW = $clog2(WINDOW_SIZE);

    // Reduce a start coordinate into the window by repeated subtraction
    function automatic logic [CW-1:0] wrap_start(input logic [START_W-1:0] a);
        logic [START_W+1:0] v;
        v = (START_W+2)'(a);
        for (int k = 0; k < 8; k++) begin
            if (v >= (START_W+2)'(WINDOW_SIZE)) begin
                v = v - (START_W+2)'(WINDOW_SIZE);
            end
        end
        return v[CW-1:0];
    endfunction

    logic [COUNT_W-1:0] r_col_count, n_col_count;
    logic [COUNT_W-1:0] r_row_count, n_row_count;
    logic [BANK_W-1:0]  r_bank, n_bank;
    logic [CW-1:0]      r_x0, n_x0;
    logic [CW-1:0]      r_y0, n_y0;
    logic [COUNT_W-1:0] r_col_pos, n_col_pos;
    logic [COUNT_W-1:0] r_row_pos, n_row_pos;
    logic [CW-1:0]      r_x, n_x;
    logic [CW-1:0]      r_y, n_y;

    logic [COUNT_W-1:0]   col_inc;
    logic [COUNT_W-1:0]   row_inc;
    logic [CW-1:0]        x_inc;
    logic [CW-1:0]        y_inc;
    logic [MAP_ROW_W-1:0] map_row;
    logic                 empty;
    logic                 outside;
    t_cell_issue          issue;

    always_comb begin
        col_inc = r_col_pos + 1'b1;
        row_inc = r_row_pos + 1'b1;
        x_inc   = (r_x == CW'(WINDOW_SIZE - 1)) ? '0 : r_x + 1'b1;
        y_inc   = (r_y == CW'(WINDOW_SIZE - 1)) ? '0 : r_y + 1'b1;
        map_row = MAP_ROW_W'(r_y) + MAP_ROW_W'(r_bank) * MAP_ROW_W'(WINDOW_SIZE);
        empty   = (r_col_count == '0) || (r_row_count == '0);
        outside = (r_col_pos >= r_col_count) || (r_row_pos >= r_row_count);

        issue.emit   = !empty && !outside;
        issue.offset = {map_row, MAP_COL_W'(r_x), BYTE_SEL_W'(0)};
        issue.done   = (col_inc >= r_col_count) && (row_inc >= r_row_count);

        n_col_count = r_col_count;
        n_row_count = r_row_count;
        n_bank      = r_bank;
        n_x0        = r_x0;
        n_y0        = r_y0;
        n_col_pos   = r_col_pos;
        n_row_pos   = r_row_pos;
        n_x         = r_x;
        n_y         = r_y;

        if (i_cfg_wr) begin
            case (i_cfg_index)
                REG_COLUMN_COUNT: n_col_count = i_cfg_data;
                REG_ROW_COUNT:    n_row_count = i_cfg_data;
                REG_MAP_BANK:     n_bank      = i_cfg_data[BANK_W-1:0];
                REG_START_COLUMN: n_x0        = wrap_start(i_cfg_data[START_W-1:0]);
                REG_START_ROW:    n_y0        = wrap_start(i_cfg_data[START_W-1:0]);
                default: ;
            endcase
            // Any known register restarts the rectangle
            if (i_cfg_index <= REG_START_ROW) begin
                n_col_pos = '0;
                n_row_pos = '0;
                n_x       = n_x0;
                n_y       = n_y0;
            end
        end else if (i_cell_accept && !empty) begin
            if (outside) begin
                n_col_pos = '0;
                n_row_pos = '0;
                n_x       = r_x0;
                n_y       = r_y0;
            end else if (col_inc >= r_col_count) begin
                n_col_pos = '0;
                n_x       = r_x0;
                if (row_inc >= r_row_count) begin
                    n_row_pos = '0;
                    n_y       = r_y0;
                end else begin
                    n_row_pos = row_inc;
                    n_y       = y_inc;
                end
            end else begin
                n_col_pos = col_inc;
                n_x       = x_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_count <= '0;
            r_row_count <= '0;
            r_bank      <= '0;
            r_x0        <= '0;
            r_y0        <= '0;
            r_col_pos   <= '0;
            r_row_pos   <= '0;
            r_x         <= '0;
            r_y         <= '0;
        end else begin
            r_col_count <= n_col_count;
            r_row_count <= n_row_count;
            r_bank      <= n_bank;
            r_x0        <= n_x0;
            r_y0        <= n_y0;
            r_col_pos   <= n_col_pos;
            r_row_pos   <= n_row_pos;
            r_x         <= n_x;
            r_y         <= n_y;
        end
    end

    assign o_issue = issue;

endmodule

>>> rtl/mmb_out.sv
module mmb_out (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_load,
    input  mmb_pkg::t_cell_issue              i_issue,
    input  logic [2*mmb_pkg::WORD_W-1:0]      i_pair,
    output logic                              o_open,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [mmb_pkg::OFFSET_W-1:0]      o_write_offset,
    output logic [mmb_pkg::WORD_W-1:0]        o_write_data,
    output logic                              o_pair_last,
    output logic                              o_blit_done
);
    import mmb_pkg::*;

    // Cell waiting for its two beats; pair data from the table arrives in the cycle after load
    logic                r_s1_valid;
    logic                r_phase;
    logic [OFFSET_W-1:0] r_s1_offset;
    logic                r_s1_done;

    logic                r_o_valid;
    logic [OFFSET_W-1:0] r_o_offset;
    logic [WORD_W-1:0]   r_o_data;
    logic                r_o_last;
    logic                r_o_done;

    logic out_free;
    logic move;

    assign out_free = !r_o_valid || !i_out_stall;
    assign move     = r_s1_valid && out_free;
    assign o_open   = !r_s1_valid || (move && r_phase);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_phase    <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_load) begin
                r_s1_valid <= 1'b1;
                r_phase    <= 1'b0;
            end else if (move) begin
                if (r_phase) begin
                    r_s1_valid <= 1'b0;
                end
                r_phase <= 1'b1;
            end
            if (move) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_s1_offset <= i_issue.offset;
            r_s1_done   <= i_issue.done;
        end
        if (move) begin
            r_o_offset <= r_phase ? r_s1_offset + PAIR_GAP : r_s1_offset;
            r_o_data   <= r_phase ? i_pair[2*WORD_W-1:WORD_W] : i_pair[WORD_W-1:0];
            r_o_last   <= r_phase;
            r_o_done   <= r_phase && r_s1_done;
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_write_offset = r_o_offset;
    assign o_write_data   = r_o_data;
    assign o_pair_last    = r_o_last;
    assign o_blit_done    = r_o_done;

endmodule

>>> rtl/metatile_map_blit.sv
// Metatile map blitter. A load beat (command 0) writes one word pair into the
// metatile table; a cell beat (command 1) looks up the pair selected by the low
// bits of cell_word and produces two write beats, the first word at the cell's
// map offset, the second 0x40 bytes (half a map row) lower. Cells are taken in
// row-major order over a column_count by row_count rectangle; the destination
// column and row wrap inside a WINDOW_SIZE window and map_bank picks which block
// of WINDOW_SIZE rows is written. pair_last marks the second beat of a pair and
// blit_done the last beat of the rectangle, after which the cursor restarts.
// Cells on an empty rectangle, or past its end after a register shrank, give no
// beats. Each cell produces two write beats through the single output register,
// so a new cell is taken only once the previous cell's second beat moves out,
// which an output stall holds back; a load is accepted even while the output is
// stalled. Write data passes the table read register and then the output
// register. Table entries must be loaded before a cell reads them; a write to
// any listed register restarts the rectangle, a write to an index past the list
// is dropped, and configuration must only be written while the block is idle.
module metatile_map_blit #(
    parameter int TABLE_ENTRIES = 4096,
    parameter int WINDOW_SIZE   = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    // Configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mmb_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [mmb_pkg::CFG_DATA_W-1:0]  i_cfg_data,

    // Input beats
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_command,
    input  logic [mmb_pkg::CELL_INDEX_W-1:0] i_table_index,
    input  logic [mmb_pkg::WORD_W-1:0]      i_first_word,
    input  logic [mmb_pkg::WORD_W-1:0]      i_second_word,
    input  logic [mmb_pkg::WORD_W-1:0]      i_cell_word,

    // Write beats
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [mmb_pkg::OFFSET_W-1:0]    o_write_offset,
    output logic [mmb_pkg::WORD_W-1:0]      o_write_data,
    output logic                            o_pair_last,
    output logic                            o_blit_done
);
    import mmb_pkg::*;

    localparam int AW = $clog2(TABLE_ENTRIES);

    logic                cmd_cell;
    logic                cell_accept;
    logic                load_accept;
    logic                cfg_wr;
    logic                open;
    t_cell_issue         issue;
    logic [2*WORD_W-1:0] pair;

    // Loads never wait; a cell waits until the previous cell's second beat leaves
    assign cmd_cell    = (i_command == CMD_CELL);
    assign o_in_stall  = cmd_cell && !open;
    assign cell_accept = i_in_valid && cmd_cell && open;
    assign load_accept = i_in_valid && (i_command == CMD_LOAD);

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;

    mmb_cursor #(
        .WINDOW_SIZE(WINDOW_SIZE)
    ) u_cursor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr     (cfg_wr),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_cell_accept(cell_accept),
        .o_issue      (issue)
    );

    // Table read is issued only for cells that produce beats; a load written
    // in an earlier cycle is seen by a read in any later cycle
    mmb_table #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_table (
        .i_clk    (i_clk),
        .i_wr_en  (load_accept),
        .i_wr_addr(i_table_index[AW-1:0]),
        .i_wr_data({i_second_word, i_first_word}),
        .i_rd_en  (cell_accept && issue.emit),
        .i_rd_addr(i_cell_word[AW-1:0]),
        .o_rd_data(pair)
    );

    mmb_out u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (cell_accept && issue.emit),
        .i_issue       (issue),
        .i_pair        (pair),
        .o_open        (open),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_write_offset(o_write_offset),
        .o_write_data  (o_write_data),
        .o_pair_last   (o_pair_last),
        .o_blit_done   (o_blit_done)
    );

endmodule
